@@ rtl/erv3_pkg.sv @@
// ----------------------------------------------------------------------------
// erv3_pkg
// Shared constants for the Euler vector rotation core: default widths,
// CORDIC gain and arctangent table, pipeline latencies, quadrant codes.
// ----------------------------------------------------------------------------
package erv3_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF     = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;   // cordic x/y datapath width
  localparam int ANGLE_ACC_W  = 32;   // cordic residual angle width
  localparam int TRIG_W       = 32;   // signed Q1.30 sine/cosine
  localparam int TRIG_MAG_W   = 31;   // magnitude of a trig value, up to 2^30

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] TRIG_ONE    = 34'sd1073741824;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // setup stage + one stage per cordic step + clamp/quadrant stage
  localparam int TRIG_LAT = CORDIC_STEPS + 2;
  // magnitude, partial products, rounding, add/saturate
  localparam int ROT_LAT  = 4;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

endpackage

@@ rtl/erv3_delay.sv @@
// ----------------------------------------------------------------------------
// erv3_delay
// Payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module erv3_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

@@ rtl/erv3_sincos.sv @@
// ----------------------------------------------------------------------------
// erv3_sincos
// Pipelined CORDIC sine/cosine of a binary angle, one step per stage,
// clamped to [-1, 1] in Q1.30 and rotated into the right quadrant.
// ----------------------------------------------------------------------------
module erv3_sincos
  import erv3_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ANGLE_WIDTH-1:0]   angle,
  output logic signed [TRIG_W-1:0] sin_val,
  output logic signed [TRIG_W-1:0] cos_val
);

  logic signed [CORDIC_W-1:0]    xs [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]    ys [CORDIC_STEPS+1];
  logic signed [ANGLE_ACC_W-1:0] zs [CORDIC_STEPS+1];
  logic [1:0]                    qs [CORDIC_STEPS+1];

  logic [31:0] turn;
  logic [31:0] shifted;

  // fold to [-1/8, 1/8) turn plus a quadrant
  assign turn    = {angle, {(32-ANGLE_WIDTH){1'b0}}};
  assign shifted = turn + 32'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= $signed({2'b00, shifted[29:0]}) - 32'sh2000_0000;
      qs[0] <= shifted[31:30];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0]    dx;
    logic signed [CORDIC_W-1:0]    dy;
    logic signed [ANGLE_ACC_W-1:0] da;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = $signed({2'b00, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][ANGLE_ACC_W-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end
        qs[i+1] <= qs[i];
      end
    end
  end

  logic signed [CORDIC_W-1:0] xc;
  logic signed [CORDIC_W-1:0] yc;
  logic signed [CORDIC_W-1:0] sin_w;
  logic signed [CORDIC_W-1:0] cos_w;

  always_comb begin
    xc = xs[CORDIC_STEPS];
    if (xc > TRIG_ONE)  xc = TRIG_ONE;
    if (xc < -TRIG_ONE) xc = -TRIG_ONE;
    yc = ys[CORDIC_STEPS];
    if (yc > TRIG_ONE)  yc = TRIG_ONE;
    if (yc < -TRIG_ONE) yc = -TRIG_ONE;
    case (qs[CORDIC_STEPS])
      QUAD_0:  begin cos_w = xc;  sin_w = yc;  end
      QUAD_1:  begin cos_w = -yc; sin_w = xc;  end
      QUAD_2:  begin cos_w = -xc; sin_w = -yc; end
      default: begin cos_w = yc;  sin_w = -xc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= TRIG_W'(sin_w);
      cos_val <= TRIG_W'(cos_w);
    end
  end

endmodule

@@ rtl/erv3_rotate.sv @@
// ----------------------------------------------------------------------------
// erv3_rotate
// One planar rotation: p = u*c - v*s, q = u*s + v*c. Each product is
// rounded half away from zero to the component format, sums saturate.
// ----------------------------------------------------------------------------
module erv3_rotate
  import erv3_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COMPONENT_WIDTH-1:0] u,
  input  logic signed [COMPONENT_WIDTH-1:0] v,
  input  logic signed [TRIG_W-1:0]          s,
  input  logic signed [TRIG_W-1:0]          c,
  output logic signed [COMPONENT_WIDTH-1:0] p,
  output logic signed [COMPONENT_WIDTH-1:0] q
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int PW   = (W > 25) ? W : 25;    // padded magnitude width
  localparam int AHW  = PW - 24;              // upper slice width
  localparam int LOW  = 24 + TRIG_MAG_W;
  localparam int HIW  = AHW + TRIG_MAG_W;
  localparam int FW   = PW + TRIG_MAG_W + 1;
  localparam int MW   = FW - 30;
  localparam int SW   = MW + 1;
  localparam int SUMW = SW + 1;

  localparam logic signed [SUMW-1:0] MAXV = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MINV = {{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [FW-1:0]          HALF = FW'(64'd1 << 29);

  // product order: u*c, v*s, u*s, v*c
  logic [W-1:0]          um, vm;
  logic [TRIG_MAG_W-1:0] sm, cm;
  logic [PW-1:0]         amag_next [4];
  logic [TRIG_MAG_W-1:0] tmag_next [4];
  logic [3:0]            neg_next;

  always_comb begin
    um = u[W-1] ? (~u + 1'b1) : u;
    vm = v[W-1] ? (~v + 1'b1) : v;
    sm = s[TRIG_W-1] ? TRIG_MAG_W'(~s + 1'b1) : TRIG_MAG_W'(s);
    cm = c[TRIG_W-1] ? TRIG_MAG_W'(~c + 1'b1) : TRIG_MAG_W'(c);
    amag_next[0] = PW'(um);  tmag_next[0] = cm;  neg_next[0] = u[W-1] ^ c[TRIG_W-1];
    amag_next[1] = PW'(vm);  tmag_next[1] = sm;  neg_next[1] = v[W-1] ^ s[TRIG_W-1];
    amag_next[2] = PW'(um);  tmag_next[2] = sm;  neg_next[2] = u[W-1] ^ s[TRIG_W-1];
    amag_next[3] = PW'(vm);  tmag_next[3] = cm;  neg_next[3] = v[W-1] ^ c[TRIG_W-1];
  end

  logic [PW-1:0]         amag [4];
  logic [TRIG_MAG_W-1:0] tmag [4];
  logic [3:0]            neg1, neg2, neg3;
  logic [LOW-1:0]        lo [4];
  logic [HIW-1:0]        hi [4];
  logic [MW-1:0]         mag [4];
  logic [FW-1:0]         full [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      full[k] = FW'({hi[k], 24'b0}) + FW'(lo[k]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= neg_next;
      neg2 <= neg1;
      neg3 <= neg2;
      for (int k = 0; k < 4; k++) begin
        amag[k] <= amag_next[k];
        tmag[k] <= tmag_next[k];
        lo[k]   <= LOW'(amag[k][23:0] * tmag[k]);
        hi[k]   <= HIW'(amag[k][PW-1:24] * tmag[k]);
        mag[k]  <= full[k][FW-1:30];
      end
    end
  end

  logic signed [SW-1:0]   sv [4];
  logic signed [SUMW-1:0] p_sum, q_sum, p_sat, q_sat;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sv[k] = neg3[k] ? -$signed({1'b0, mag[k]}) : $signed({1'b0, mag[k]});
    end
    p_sum = SUMW'(sv[0]) - SUMW'(sv[1]);
    q_sum = SUMW'(sv[2]) + SUMW'(sv[3]);
    p_sat = (p_sum > MAXV) ? MAXV : ((p_sum < MINV) ? MINV : p_sum);
    q_sat = (q_sum > MAXV) ? MAXV : ((q_sum < MINV) ? MINV : q_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= W'(p_sat);
      q <= W'(q_sat);
    end
  end

endmodule

@@ rtl/euler_rotate_vector3_core.sv @@
// ----------------------------------------------------------------------------
// euler_rotate_vector3_core
// Rotates a Q16.16 point by pitch (about y), then yaw (about z), then roll
// (about x). Pipelined CORDIC for the trig values, rounded products and
// saturating sums for each rotation.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, x/y/z_in, 3 angles    | into core
//  output  | out_valid, out_stall, x/y/z_out           | out of core
//
//  one transaction per cycle sustained while out_stall stays low; an accepted
//  input reaches out_valid through 32 cordic stages, 3 x 4 rotation stages, output register
//  rst clears valid bits only; payload registers are not reset
//  a stalled output parks one result in a skid register; in_stall is that
//  register's valid bit, so the whole pipeline holds while it is full
// ----------------------------------------------------------------------------
module euler_rotate_vector3_core
  import erv3_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] x_in,
  input  logic signed [COMPONENT_WIDTH-1:0] y_in,
  input  logic signed [COMPONENT_WIDTH-1:0] z_in,
  input  logic signed [ANGLE_WIDTH-1:0]     roll_angle,
  input  logic signed [ANGLE_WIDTH-1:0]     pitch_angle,
  input  logic signed [ANGLE_WIDTH-1:0]     yaw_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] x_out,
  output logic signed [COMPONENT_WIDTH-1:0] y_out,
  output logic signed [COMPONENT_WIDTH-1:0] z_out
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int LAT = TRIG_LAT + 3 * ROT_LAT;

  logic en;
  logic skid_valid;

  // pipeline moves whenever the skid register is empty
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // trig for all three angles in parallel
  logic signed [TRIG_W-1:0] sr, cr, sp, cp, sw, cw;

  erv3_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_roll (
    .clk(clk), .en(en), .angle(roll_angle), .sin_val(sr), .cos_val(cr)
  );
  erv3_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_pitch (
    .clk(clk), .en(en), .angle(pitch_angle), .sin_val(sp), .cos_val(cp)
  );
  erv3_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_yaw (
    .clk(clk), .en(en), .angle(yaw_angle), .sin_val(sw), .cos_val(cw)
  );

  // point waits for the trig values
  logic [3*W-1:0] xyz_d;
  logic signed [W-1:0] xd, yd, zd;

  erv3_delay #(.WIDTH(3*W), .DEPTH(TRIG_LAT)) u_dly_xyz (
    .clk(clk), .en(en), .din({x_in, y_in, z_in}), .dout(xyz_d)
  );
  assign {xd, yd, zd} = xyz_d;

  // pitch: u=z, v=x gives p=z1, q=x1
  logic signed [W-1:0] x1, z1;

  erv3_rotate #(.COMPONENT_WIDTH(W)) u_rot_pitch (
    .clk(clk), .en(en), .u(zd), .v(xd), .s(sp), .c(cp), .p(z1), .q(x1)
  );

  logic [W-1:0]        y_d2;
  logic [2*TRIG_W-1:0] yaw_trig_d;
  logic signed [TRIG_W-1:0] sw_d, cw_d;

  erv3_delay #(.WIDTH(W), .DEPTH(ROT_LAT)) u_dly_y (
    .clk(clk), .en(en), .din(yd), .dout(y_d2)
  );
  erv3_delay #(.WIDTH(2*TRIG_W), .DEPTH(ROT_LAT)) u_dly_yaw_trig (
    .clk(clk), .en(en), .din({sw, cw}), .dout(yaw_trig_d)
  );
  assign {sw_d, cw_d} = yaw_trig_d;

  // yaw: u=x1, v=y gives p=x2, q=y1
  logic signed [W-1:0] x2, y1;

  erv3_rotate #(.COMPONENT_WIDTH(W)) u_rot_yaw (
    .clk(clk), .en(en), .u(x1), .v($signed(y_d2)), .s(sw_d), .c(cw_d),
    .p(x2), .q(y1)
  );

  logic [W-1:0]        z1_d;
  logic [2*TRIG_W-1:0] roll_trig_d;
  logic signed [TRIG_W-1:0] sr_d, cr_d;

  erv3_delay #(.WIDTH(W), .DEPTH(ROT_LAT)) u_dly_z1 (
    .clk(clk), .en(en), .din(z1), .dout(z1_d)
  );
  erv3_delay #(.WIDTH(2*TRIG_W), .DEPTH(2*ROT_LAT)) u_dly_roll_trig (
    .clk(clk), .en(en), .din({sr, cr}), .dout(roll_trig_d)
  );
  assign {sr_d, cr_d} = roll_trig_d;

  // roll: u=y1, v=z1 gives p=y2, q=z2
  logic signed [W-1:0] y2, z2;

  erv3_rotate #(.COMPONENT_WIDTH(W)) u_rot_roll (
    .clk(clk), .en(en), .u(y1), .v($signed(z1_d)), .s(sr_d), .c(cr_d),
    .p(y2), .q(z2)
  );

  logic [W-1:0] x2_d;

  erv3_delay #(.WIDTH(W), .DEPTH(ROT_LAT)) u_dly_x2 (
    .clk(clk), .en(en), .din(x2), .dout(x2_d)
  );

  // valid bits travel alongside the data
  logic [LAT-1:0] vpipe;
  logic           pipe_valid;

  assign pipe_valid = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  // output register plus one skid entry
  logic          load_out_pipe, load_out_skid, load_skid;
  logic [W-1:0]  skid_x, skid_y, skid_z;

  always_comb begin
    load_out_skid = skid_valid && !out_stall;
    load_out_pipe = !skid_valid && pipe_valid && (!out_valid || !out_stall);
    load_skid     = !skid_valid && pipe_valid && out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out_skid) begin
        skid_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (load_out_pipe) begin
        out_valid <= 1'b1;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      x_out <= skid_x;
      y_out <= skid_y;
      z_out <= skid_z;
    end else if (load_out_pipe) begin
      x_out <= x2_d;
      y_out <= y2;
      z_out <= z2;
    end
    if (load_skid) begin
      skid_x <= x2_d;
      skid_y <= y2;
      skid_z <= z2;
    end
  end

endmodule

@@ sim/erv3_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// erv3_checker
// Watches both channels of the rotation core, predicts each rotated point
// with a bit-exact integer model and compares it field by field.
// ----------------------------------------------------------------------------
module erv3_checker
  import erv3_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic signed [31:0]  x_in,
  input  logic signed [31:0]  y_in,
  input  logic signed [31:0]  z_in,
  input  logic signed [15:0]  roll_angle,
  input  logic signed [15:0]  pitch_angle,
  input  logic signed [15:0]  yaw_angle,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [31:0]  x_out,
  input  logic signed [31:0]  y_out,
  input  logic signed [31:0]  z_out,
  output int                  fail_count,
  output int                  pending,
  output int                  points_seen
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  point_t rotated_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // sine and cosine in Q1.30 from the cordic
  task automatic trig_of(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] turn;
    logic [1:0]  quad;
    longint      cx, cy, cz, dx, dy;
    turn = {ang, 16'h0} + 32'h2000_0000;
    quad = turn[31:30];
    cz = longint'({2'b0, turn[29:0]}) - 64'sh2000_0000;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= longint'(ATAN_TAB[i]);
      end else begin
        cx += dx; cy -= dy; cz += longint'(ATAN_TAB[i]);
      end
    end
    if (cx > 64'sd1073741824) cx = 64'sd1073741824;
    if (cx < -64'sd1073741824) cx = -64'sd1073741824;
    if (cy > 64'sd1073741824) cy = 64'sd1073741824;
    if (cy < -64'sd1073741824) cy = -64'sd1073741824;
    case (quad)
      QUAD_0: begin c = cx; s = cy; end
      QUAD_1: begin c = -cy; s = cx; end
      QUAD_2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endtask

  // round half away from zero of a*t / 2^30
  function automatic longint scale_trig(longint a, longint t);
    longint ua, ut, m;
    ua = (a < 0) ? -a : a;
    ut = (t < 0) ? -t : t;
    m = (ua * ut + 64'sd536870912) >>> 30;
    return (((a < 0) != (t < 0)) ? -m : m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic rotate_point(input logic signed [31:0] px, py, pz,
                              input logic [15:0] r, p, w, output point_t res);
    longint sr, cr, sp, cp, sw, cw, x1, z1, x2, y1, y2, z2;
    trig_of(r, sr, cr);
    trig_of(p, sp, cp);
    trig_of(w, sw, cw);
    // pitch about y
    x1 = clamp32(scale_trig(pz, sp) + scale_trig(px, cp));
    z1 = clamp32(scale_trig(pz, cp) - scale_trig(px, sp));
    // yaw about z
    x2 = clamp32(scale_trig(x1, cw) - scale_trig(py, sw));
    y1 = clamp32(scale_trig(x1, sw) + scale_trig(py, cw));
    // roll about x
    y2 = clamp32(scale_trig(y1, cr) - scale_trig(z1, sr));
    z2 = clamp32(scale_trig(y1, sr) + scale_trig(z1, cr));
    res.x = x2[31:0];
    res.y = y2[31:0];
    res.z = z2[31:0];
  endtask

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    point_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      fail_count  <= 0;
      points_seen <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        rotate_point(x_in, y_in, z_in, roll_angle, pitch_angle, yaw_angle, want);
        rotated_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        points_seen <= points_seen + 1;
        if (rotated_q.size() == 0) begin
          $error("result with no transaction outstanding");
          errs++;
        end else begin
          want = rotated_q.pop_front();
          if (x_out !== want.x) begin
            $error("x_out expected %0d got %0d", want.x, x_out);
            errs++;
          end
          if (y_out !== want.y) begin
            $error("y_out expected %0d got %0d", want.y, y_out);
            errs++;
          end
          if (z_out !== want.z) begin
            $error("z_out expected %0d got %0d", want.z, z_out);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ sim/tb_euler_rotate_vector3_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_rotate_vector3_core
// Drives directed and random points and angles into the rotation core with
// random gaps and output stalls; a checker beside the core scores results.
// ----------------------------------------------------------------------------
module tb_euler_rotate_vector3_core;

  localparam int RANDOM_POINTS = 400;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] x_in = '0, y_in = '0, z_in = '0;
  logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] x_out, y_out, z_out;
  int                 fail_count, pending, points_seen;
  int                 cycle_count = 0;
  bit                 calm = 1'b0;   // no idling on either side

  always #4 clk = ~clk;

  euler_rotate_vector3_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_in(x_in), .y_in(y_in), .z_in(z_in),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .x_out(x_out), .y_out(y_out), .z_out(z_out)
  );

  erv3_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_in(x_in), .y_in(y_in), .z_in(z_in),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .x_out(x_out), .y_out(y_out), .z_out(z_out),
    .fail_count(fail_count), .pending(pending), .points_seen(points_seen)
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls about 13 percent of cycles, never during the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  // component mixes full-range, small and saturation-edge values
  function automatic logic [31:0] pick_component();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return $urandom_range(1) ? 32'h7fff_ff00 + $urandom_range(255)
                                  : 32'h8000_0000 + $urandom_range(255);
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  // angles near the octant and quadrant edges are of most interest
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(2) == 0)
      return 16'($urandom_range(15) * 16'h1000 + $urandom_range(2) - 1);
    return $urandom;
  endfunction

  // one input transaction, held until accepted; valid drops only while idling
  task automatic send_point(input logic [31:0] px, py, pz,
                            input logic [15:0] r, p, w);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    x_in <= px; y_in <= py; z_in <= pz;
    roll_angle <= r; pitch_angle <= p; yaw_angle <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: a unit vector, extremes of every field, quadrant edges
    send_point(32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000, 16'h0, 16'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0, 16'h4000, 16'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0, 16'h0, 16'h4000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h2000, 16'h2000, 16'h2000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 16'hffff, 16'h1fff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hc000, 16'hdfff, 16'he000);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 16'h6000, 16'ha000, 16'h5fff);
    send_point(32'h0, 32'h0, 32'h0, 16'hffff, 16'h8001, 16'h0001);
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0000_7fff, 16'h1000, 16'h3000, 16'hf000);
    send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 16'h5555, 16'haaaa, 16'h5555);

    // random part, with a stretch of back-to-back traffic in the middle
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      calm = (n >= 150 && n < 230);
      send_point(pick_component(), pick_component(), pick_component(),
                 pick_angle(), pick_angle(), pick_angle());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("rotated %0d points through directed extremes and random angles,",
             points_seen);
    $display("with random input gaps and output stalls; %0d mismatches", fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
